// ----- sv/zdt_pkg.sv -----
package zdt_pkg;

  // defaults for the top-level parameters
  localparam int NUM_ZONES_DEF = 8;
  localparam int FPS_DEF       = 60;

  // largest dwell time in seconds (8-bit field)
  localparam int MAX_SECONDS = 255;

  // fixed field widths
  localparam int COORD_W = 10;
  localparam int SEC_W   = 8;
  localparam int DIAM_W  = 8;
  localparam int THR_W   = 11;
  localparam int SLOT_W  = 3;
  localparam int PROG_W  = 14;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 11;
  localparam int PROD_W = 2 * MUL_W;

  // action codes
  localparam logic ACT_DEFINE = 1'b0;
  localparam logic ACT_POLL   = 1'b1;

  // configuration register indexes
  localparam logic CFG_DIAMETER  = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  // reset values of the configuration registers
  localparam logic [DIAM_W-1:0] DIAMETER_RST  = 8'd16;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 11'd32;

  typedef struct packed {
    logic               touch;
    logic [SEC_W-1:0]   seconds;
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } zone_t;

  // write strobes into the zone table
  typedef struct packed {
    logic def_wr;  // define a slot (also clears its dwell counter)
    logic cnt_wr;  // store an updated dwell counter
  } tbl_ctl_t;

endpackage

// ----- sv/zdt_table.sv -----
module zdt_table #(
  parameter int NUM_ZONES = zdt_pkg::NUM_ZONES_DEF,
  parameter int CNT_W     = 14,
  localparam int IDX_W    = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  zdt_pkg::tbl_ctl_t    ctl,
  input  logic [IDX_W-1:0]     def_addr,
  input  zdt_pkg::zone_t       def_zone,
  input  logic [IDX_W-1:0]     addr,
  input  logic [CNT_W-1:0]     cnt_data,
  output zdt_pkg::zone_t       rd_zone,
  output logic                 rd_valid,
  output logic [CNT_W-1:0]     rd_cnt
);

  zdt_pkg::zone_t   zone_mem [NUM_ZONES];
  logic [CNT_W-1:0] dwell_mem [NUM_ZONES];
  logic [NUM_ZONES-1:0] valid;

  // zone entries: written by define, read registered at the sequencer address
  always_ff @(posedge clk) begin
    if (ctl.def_wr) begin
      zone_mem[def_addr] <= def_zone;
    end
    rd_zone <= zone_mem[addr];
  end

  // dwell counters: cleared by define, updated at the end of each zone step
  always_ff @(posedge clk) begin
    if (ctl.def_wr) begin
      dwell_mem[def_addr] <= '0;
    end else if (ctl.cnt_wr) begin
      dwell_mem[addr] <= cnt_data;
    end
    rd_cnt <= dwell_mem[addr];
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.def_wr) begin
      valid[def_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid[addr];
  end

endmodule

// ----- sv/zone_dwell_trigger.sv -----
// Define item: taken when start is seen while idle, gives no result; busy stays low.
// Poll item: one result per zone, each zone stepped through the states RD, PREP,
// SQX, SQY, THR, LIM and UPD in turn. One 11x11 multiplier is
// reused for dx^2, dy^2, threshold^2 and the dwell limit of each zone.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset (synchronous) clears all zone valid bits and restores the registers.
module zone_dwell_trigger #(
  parameter int NUM_ZONES         = zdt_pkg::NUM_ZONES_DEF,
  parameter int FRAMES_PER_SECOND = zdt_pkg::FPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action,
  input  logic [zdt_pkg::SLOT_W-1:0]    zone_index,
  input  logic [zdt_pkg::COORD_W-1:0]   zone_x,
  input  logic [zdt_pkg::COORD_W-1:0]   zone_y,
  input  logic [zdt_pkg::COORD_W-1:0]   zone_w,
  input  logic [zdt_pkg::COORD_W-1:0]   zone_h,
  input  logic [zdt_pkg::SEC_W-1:0]     zone_seconds,
  input  logic                          zone_touch,
  input  logic [zdt_pkg::COORD_W-1:0]   ball_x,
  input  logic [zdt_pkg::COORD_W-1:0]   ball_y,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [zdt_pkg::THR_W-1:0]     cfg_data,
  output logic                          result_valid,
  output logic [zdt_pkg::SLOT_W-1:0]    zone_number,
  output logic                          zone_active,
  output logic                          fired,
  output logic [zdt_pkg::PROG_W-1:0]    dwell_progress,
  output logic                          last
);

  localparam int IDX_W = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam int CNT_W = $clog2(zdt_pkg::MAX_SECONDS * FRAMES_PER_SECOND + 1);
  localparam int MUL_W  = zdt_pkg::MUL_W;
  localparam int PROD_W = zdt_pkg::PROD_W;
  localparam int W      = zdt_pkg::COORD_W + 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ZONES - 1);
  localparam logic [MUL_W-1:0] FPS_OP   = MUL_W'(FRAMES_PER_SECOND);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_SQX  = 3'd3;
  localparam logic [2:0] S_SQY  = 3'd4;
  localparam logic [2:0] S_THR  = 3'd5;
  localparam logic [2:0] S_LIM  = 3'd6;
  localparam logic [2:0] S_UPD  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [zdt_pkg::DIAM_W-1:0] ball_diameter;
  logic [zdt_pkg::THR_W-1:0]  prox_threshold;

  logic [zdt_pkg::COORD_W-1:0] bx;
  logic [zdt_pkg::COORD_W-1:0] by;
  logic [IDX_W-1:0]            zone_ctr;

  logic                 accept;
  zdt_pkg::tbl_ctl_t    ctl;
  zdt_pkg::zone_t       def_zone;
  zdt_pkg::zone_t       rd_zone;
  logic                 rd_valid;
  logic [CNT_W-1:0]     rd_cnt;
  logic [CNT_W-1:0]     cnt_next;
  logic                 fire_now;

  logic [W-1:0] dx;
  logic [W-1:0] dy;
  logic         touch_hit;
  logic         hit;
  logic [PROD_W:0]      acc;
  logic [CNT_W-1:0]     limit;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;

  logic [W-1:0] zcx, zcy, bcx, bcy, dx_c, dy_c;
  logic [W-1:0] bxe, bye, xhi, yhi;
  logic [W-1:0] x_lo, y_lo, bx_w, by_w;
  logic         hx, hy;
  logic [CNT_W+zdt_pkg::PROG_W-1:0] prog_ext;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ball_diameter  <= zdt_pkg::DIAMETER_RST;
      prox_threshold <= zdt_pkg::THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        zdt_pkg::CFG_DIAMETER:  ball_diameter  <= cfg_data[zdt_pkg::DIAM_W-1:0];
        zdt_pkg::CFG_THRESHOLD: prox_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // zone table and dwell counters
  assign def_zone.touch   = zone_touch;
  assign def_zone.seconds = zone_seconds;
  assign def_zone.h       = zone_h;
  assign def_zone.w       = zone_w;
  assign def_zone.y       = zone_y;
  assign def_zone.x       = zone_x;

  assign ctl.def_wr = accept && (action == zdt_pkg::ACT_DEFINE) &&
                      (7'(zone_index) < 7'(NUM_ZONES));
  assign ctl.cnt_wr = (state == S_UPD) && rd_valid;

  zdt_table #(
    .NUM_ZONES (NUM_ZONES),
    .CNT_W     (CNT_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .def_addr (IDX_W'(zone_index)),
    .def_zone (def_zone),
    .addr     (zone_ctr),
    .cnt_data (cnt_next),
    .rd_zone  (rd_zone),
    .rd_valid (rd_valid),
    .rd_cnt   (rd_cnt)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && (action == zdt_pkg::ACT_POLL)) state_next = S_RD;
      S_RD:   state_next = S_PREP;
      S_PREP: state_next = S_SQX;
      S_SQX:  state_next = S_SQY;
      S_SQY:  state_next = S_THR;
      S_THR:  state_next = S_LIM;
      S_LIM:  state_next = S_UPD;
      S_UPD:  state_next = (zone_ctr == LAST_IDX) ? S_IDLE : S_RD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      zone_ctr <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        zone_ctr <= '0;
      end else if (state == S_UPD) begin
        zone_ctr <= zone_ctr + 1'b1;
      end
    end
  end

  // ball position of the current poll
  always_ff @(posedge clk) begin
    if (accept && (action == zdt_pkg::ACT_POLL)) begin
      bx <= ball_x;
      by <= ball_y;
    end
  end

  // centre distances and edge touch test
  always_comb begin
    x_lo = W'(rd_zone.x);
    y_lo = W'(rd_zone.y);
    bx_w = W'(bx);
    by_w = W'(by);
    zcx  = x_lo + W'(rd_zone.w[zdt_pkg::COORD_W-1:1]);
    zcy  = y_lo + W'(rd_zone.h[zdt_pkg::COORD_W-1:1]);
    bcx  = bx_w + W'(ball_diameter[zdt_pkg::DIAM_W-1:1]);
    bcy  = by_w + W'(ball_diameter[zdt_pkg::DIAM_W-1:1]);
    dx_c = (zcx > bcx) ? (zcx - bcx) : (bcx - zcx);
    dy_c = (zcy > bcy) ? (zcy - bcy) : (bcy - zcy);
    bxe  = bx_w + W'(ball_diameter);
    bye  = by_w + W'(ball_diameter);
    xhi  = x_lo + W'(rd_zone.w);
    yhi  = y_lo + W'(rd_zone.h);
    hx   = ((x_lo <= bx_w) && (bx_w <= xhi)) || ((x_lo <= bxe) && (bxe <= xhi));
    hy   = ((y_lo <= by_w) && (by_w <= yhi)) || ((y_lo <= bye) && (bye <= yhi));
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      S_SQX: begin
        mul_a = dx;
        mul_b = dx;
      end
      S_SQY: begin
        mul_a = dy;
        mul_b = dy;
      end
      S_THR: begin
        mul_a = prox_threshold;
        mul_b = prox_threshold;
      end
      S_LIM: begin
        mul_a = MUL_W'(rd_zone.seconds);
        mul_b = FPS_OP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // datapath registers, one multiplier step per cycle
  always_ff @(posedge clk) begin
    case (state)
      S_PREP: begin
        dx        <= dx_c;
        dy        <= dy_c;
        touch_hit <= hx && hy;
      end
      S_SQX: acc <= (PROD_W + 1)'(prod);
      S_SQY: acc <= acc + (PROD_W + 1)'(prod);
      S_THR: hit <= rd_zone.touch ? touch_hit : (acc <= (PROD_W + 1)'(prod));
      S_LIM: limit <= prod[CNT_W-1:0];
      default: ;
    endcase
  end

  // dwell counter update
  always_comb begin
    fire_now = 1'b0;
    cnt_next = '0;
    if (hit) begin
      if (rd_cnt < limit) begin
        cnt_next = rd_cnt + 1'b1;
      end else begin
        fire_now = 1'b1;
      end
    end
  end

  assign prog_ext = {{zdt_pkg::PROG_W{1'b0}}, cnt_next};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      zone_number    <= zdt_pkg::SLOT_W'(zone_ctr);
      zone_active    <= rd_valid;
      fired          <= rd_valid && fire_now;
      dwell_progress <= rd_valid ? prog_ext[zdt_pkg::PROG_W-1:0] : '0;
      last           <= (zone_ctr == LAST_IDX);
    end
  end

endmodule

// ----- tb/zone_dwell_trigger_tb.sv -----
`timescale 1ns / 1ps

module zone_dwell_trigger_tb;

  localparam int NZ           = zdt_pkg::NUM_ZONES_DEF;
  localparam int FPS          = zdt_pkg::FPS_DEF;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  // one command to the block: a zone definition or a ball poll
  typedef struct {
    logic                        act;
    logic [zdt_pkg::SLOT_W-1:0]  slot;
    zdt_pkg::zone_t              geom;
    logic [zdt_pkg::COORD_W-1:0] bx;
    logic [zdt_pkg::COORD_W-1:0] by;
  } zone_cmd_t;

  // one per-zone report of a poll
  typedef struct {
    logic [zdt_pkg::SLOT_W-1:0] slot;
    logic                       active;
    logic                       fired;
    logic [zdt_pkg::PROG_W-1:0] progress;
    logic                       last;
  } zone_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic action = zdt_pkg::ACT_DEFINE;
  logic [zdt_pkg::SLOT_W-1:0] zone_index = '0;
  logic [zdt_pkg::COORD_W-1:0] zone_x = '0, zone_y = '0, zone_w = '0, zone_h = '0;
  logic [zdt_pkg::SEC_W-1:0] zone_seconds = '0;
  logic zone_touch = 1'b0;
  logic [zdt_pkg::COORD_W-1:0] ball_x = '0, ball_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = zdt_pkg::CFG_DIAMETER;
  logic [zdt_pkg::THR_W-1:0] cfg_data = '0;
  logic result_valid;
  logic [zdt_pkg::SLOT_W-1:0] zone_number;
  logic zone_active;
  logic fired;
  logic [zdt_pkg::PROG_W-1:0] dwell_progress;
  logic last;

  zone_dwell_trigger dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .zone_index(zone_index),
    .zone_x(zone_x), .zone_y(zone_y), .zone_w(zone_w), .zone_h(zone_h),
    .zone_seconds(zone_seconds), .zone_touch(zone_touch),
    .ball_x(ball_x), .ball_y(ball_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid), .zone_number(zone_number),
    .zone_active(zone_active), .fired(fired),
    .dwell_progress(dwell_progress), .last(last)
  );

  always #2 clk = ~clk;

  // commands waiting to go out, and reports still owed by the block
  zone_cmd_t    cmd_fifo[$];
  zone_report_t due_reports[$];
  zone_cmd_t    on_port;

  // predictor state: zone table, dwell counters, registers
  zdt_pkg::zone_t             zone_tab[NZ];
  bit                         zone_valid[NZ];
  int                         dwell[NZ];
  logic [zdt_pkg::DIAM_W-1:0] diam   = zdt_pkg::DIAMETER_RST;
  logic [zdt_pkg::THR_W-1:0]  thresh = zdt_pkg::THRESHOLD_RST;

  // stimulus-side copy of the layout, used to aim the ball
  zdt_pkg::zone_t layout[NZ];
  bit             layout_ok[NZ];

  int errors = 0;
  int cycles = 0;
  int sent_count = 0;
  int defines_sent = 0;
  int polls_sent = 0;
  int reports_seen = 0;
  int fires_seen = 0;
  int regs_written = 0;

  // hit test for one zone against a ball at (bx, by)
  function automatic bit zone_hit(zdt_pkg::zone_t z, int bx, int by);
    int zx, zy, zw, zh, d;
    longint dx, dy, t;
    bit hx, hy;
    zx = int'(z.x);
    zy = int'(z.y);
    zw = int'(z.w);
    zh = int'(z.h);
    d  = int'(diam);
    if (z.touch) begin
      hx = (bx >= zx && bx <= zx + zw) || (bx + d >= zx && bx + d <= zx + zw);
      hy = (by >= zy && by <= zy + zh) || (by + d >= zy && by + d <= zy + zh);
      return hx && hy;
    end
    dx = longint'(zx + zw / 2) - longint'(bx + d / 2);
    dy = longint'(zy + zh / 2) - longint'(by + d / 2);
    t  = longint'(thresh);
    return dx * dx + dy * dy <= t * t;
  endfunction

  // update predictor state for an accepted command, queue the reports it owes
  function automatic void apply_cmd(zone_cmd_t c);
    zone_report_t r;
    int lim;
    if (c.act == zdt_pkg::ACT_DEFINE) begin
      zone_tab[c.slot] = c.geom;
      zone_valid[c.slot] = 1'b1;
      dwell[c.slot] = 0;
      defines_sent++;
      return;
    end
    polls_sent++;
    for (int i = 0; i < NZ; i++) begin
      r = '{slot: zdt_pkg::SLOT_W'(i), active: 1'b0, fired: 1'b0, progress: '0,
            last: (i == NZ - 1)};
      if (zone_valid[i]) begin
        lim = int'(zone_tab[i].seconds) * FPS;
        if (zone_hit(zone_tab[i], int'(c.bx), int'(c.by))) begin
          if (dwell[i] < lim) begin
            dwell[i]++;
          end else begin
            r.fired = 1'b1;
            dwell[i] = 0;
          end
        end else begin
          dwell[i] = 0;
        end
        r.active = 1'b1;
        r.progress = zdt_pkg::PROG_W'(dwell[i]);
      end
      due_reports = {due_reports, r};
    end
  endfunction

  function automatic void check_field(string name, int slot, int want, int got);
    if (want != got) begin
      $display("%0t: zone %0d %s expected %0d got %0d", $time, slot, name, want, got);
      errors++;
    end
  endfunction

  function automatic logic [zdt_pkg::COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 1023) return 10'd1023;
    return zdt_pkg::COORD_W'(v);
  endfunction

  // unused fields of each command carry random values
  function automatic zone_cmd_t define_cmd(int slot, int x, int y, int w, int h,
                                           int sec, bit touch);
    zone_cmd_t c;
    c.act = zdt_pkg::ACT_DEFINE;
    c.slot = zdt_pkg::SLOT_W'(slot);
    c.geom = '{touch: touch, seconds: zdt_pkg::SEC_W'(sec),
               h: zdt_pkg::COORD_W'(h), w: zdt_pkg::COORD_W'(w),
               y: zdt_pkg::COORD_W'(y), x: zdt_pkg::COORD_W'(x)};
    c.bx = zdt_pkg::COORD_W'($urandom);
    c.by = zdt_pkg::COORD_W'($urandom);
    return c;
  endfunction

  function automatic zone_cmd_t poll_cmd(int bx, int by);
    zone_cmd_t c;
    c.act = zdt_pkg::ACT_POLL;
    c.slot = zdt_pkg::SLOT_W'($urandom);
    c.geom = zdt_pkg::zone_t'($bits(zdt_pkg::zone_t)'({$urandom, $urandom}));
    c.bx = zdt_pkg::COORD_W'(bx);
    c.by = zdt_pkg::COORD_W'(by);
    return c;
  endfunction

  function automatic void queue_cmd(zone_cmd_t c);
    if (c.act == zdt_pkg::ACT_DEFINE) begin
      layout[c.slot] = c.geom;
      layout_ok[c.slot] = 1'b1;
    end
    cmd_fifo = {cmd_fifo, c};
  endfunction

  // random zone: mostly short dwell times so zones actually fire
  function automatic zone_cmd_t random_define(int slot);
    int sel, sec;
    int w, h;
    sel = $urandom_range(99);
    sec = (sel < 45) ? 0 : (sel < 80) ? 1 : $urandom_range(255);
    w = $urandom_range(1) ? $urandom_range(1023) : $urandom_range(4, 120);
    h = $urandom_range(1) ? $urandom_range(1023) : $urandom_range(4, 120);
    return define_cmd(slot, $urandom_range(1023), $urandom_range(1023), w, h, sec,
                      $urandom_range(1));
  endfunction

  // random phase: a few zones, then runs of polls hovering over one zone,
  // with stray polls and redefinitions between runs
  task automatic plan_phase(input int n_items);
    int made, aim, run_len, half, cx, cy;
    made = 0;
    repeat ($urandom_range(3, 6)) begin
      queue_cmd(random_define($urandom_range(NZ - 1)));
      made++;
    end
    while (made < n_items) begin
      aim = $urandom_range(NZ - 1);
      if (!layout_ok[aim]) begin
        queue_cmd(random_define(aim));
        made++;
      end
      run_len = ($urandom_range(99) < 30) ? $urandom_range(62, 75) : $urandom_range(2, 20);
      half = int'(diam) / 2;
      cx = int'(layout[aim].x) + int'(layout[aim].w) / 2 - half;
      cy = int'(layout[aim].y) + int'(layout[aim].h) / 2 - half;
      for (int k = 0; k < run_len && made < n_items; k++) begin
        queue_cmd(poll_cmd(clamp_coord(cx + $urandom_range(4) - 2),
                           clamp_coord(cy + $urandom_range(4) - 2)));
        made++;
      end
      repeat ($urandom_range(2)) begin
        if ($urandom_range(1))
          queue_cmd(poll_cmd($urandom_range(1023), $urandom_range(1023)));
        else
          queue_cmd(random_define($urandom_range(NZ - 1)));
        made++;
      end
    end
  endtask

  // wait until every command is taken and every report has come back;
  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    while (cmd_fifo.size() != 0 || start || due_reports.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [zdt_pkg::THR_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == zdt_pkg::CFG_DIAMETER)
      diam = data[zdt_pkg::DIAM_W-1:0];
    else
      thresh = data;
    regs_written++;
  endtask

  // command driver: holds start until the transfer, idles at random
  always @(posedge clk) begin
    bit calm;
    calm = (sent_count >= 90 && sent_count < 150);
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_cmd(on_port);
        sent_count++;
      end
      if (!start || !busy) begin
        if (cmd_fifo.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
          on_port = cmd_fifo.pop_front();
          action <= on_port.act;
          zone_index <= on_port.slot;
          zone_x <= on_port.geom.x;
          zone_y <= on_port.geom.y;
          zone_w <= on_port.geom.w;
          zone_h <= on_port.geom.h;
          zone_seconds <= on_port.geom.seconds;
          zone_touch <= on_port.geom.touch;
          ball_x <= on_port.bx;
          ball_y <= on_port.by;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // report monitor: every strobed report against the oldest expectation
  always @(posedge clk) begin
    zone_report_t want;
    if (!rst && result_valid) begin
      reports_seen++;
      if (fired) fires_seen++;
      if (due_reports.size() == 0) begin
        $display("%0t: report for zone %0d with none expected", $time, zone_number);
        errors++;
      end else begin
        want = due_reports.pop_front();
        check_field("zone_number", want.slot, want.slot, zone_number);
        check_field("zone_active", want.slot, want.active, zone_active);
        check_field("fired", want.slot, want.fired, fired);
        check_field("dwell_progress", want.slot, want.progress, dwell_progress);
        check_field("last", want.slot, want.last, last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d reports still owed", $time, due_reports.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, edge and boundary hits, zero dwell, redefinition
    queue_cmd(poll_cmd(0, 0));
    queue_cmd(poll_cmd(1023, 1023));
    queue_cmd(define_cmd(0, 100, 100, 50, 50, 0, 1'b1));
    queue_cmd(define_cmd(7, 0, 0, 0, 0, 1, 1'b0));
    queue_cmd(define_cmd(3, 1023, 1023, 1023, 1023, 255, 1'b1));
    queue_cmd(define_cmd(5, 1023, 1023, 1023, 1023, 2, 1'b0));
    queue_cmd(poll_cmd(110, 110));
    queue_cmd(poll_cmd(110, 110));
    queue_cmd(poll_cmd(84, 84));
    queue_cmd(poll_cmd(150, 150));
    queue_cmd(poll_cmd(151, 151));
    queue_cmd(poll_cmd(0, 0));
    queue_cmd(poll_cmd(0, 0));
    // proximity centre at (0,8): ball at 24,0 sits exactly on the threshold
    queue_cmd(define_cmd(7, 0, 0, 0, 16, 1, 1'b0));
    queue_cmd(poll_cmd(24, 0));
    queue_cmd(poll_cmd(25, 0));
    queue_cmd(poll_cmd(1023, 1023));
    queue_cmd(define_cmd(0, 100, 100, 50, 50, 255, 1'b0));
    queue_cmd(poll_cmd(1023, 1023));
    wait_idle();

    // register extremes first, then random settings
    write_reg(zdt_pkg::CFG_DIAMETER, {3'($urandom), 8'd0});
    write_reg(zdt_pkg::CFG_THRESHOLD, 11'd0);
    plan_phase(65);
    wait_idle();

    write_reg(zdt_pkg::CFG_DIAMETER, {3'($urandom), 8'd255});
    write_reg(zdt_pkg::CFG_THRESHOLD, 11'd2047);
    plan_phase(65);
    wait_idle();

    repeat (2) begin
      write_reg(zdt_pkg::CFG_DIAMETER, zdt_pkg::THR_W'($urandom));
      write_reg(zdt_pkg::CFG_THRESHOLD,
                $urandom_range(1) ? zdt_pkg::THR_W'($urandom_range(200))
                                  : zdt_pkg::THR_W'($urandom));
      plan_phase(65);
      wait_idle();
    end

    $display("Covered %0d defines and %0d polls over %0d register writes.",
             defines_sent, polls_sent, regs_written);
    $display("Checked %0d zone reports, %0d of them firing.", reports_seen, fires_seen);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/zdt_pkg.sv
sv/zdt_table.sv
sv/zone_dwell_trigger.sv
tb/zone_dwell_trigger_tb.sv
